### rtl/pfd_pkg.sv
// shared types, constants and control word layout for the pruefer sequence decoder
`default_nettype none

package pfd_pkg;

    // fixed field widths and default vertex count
    localparam int LABEL_W          = 6;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 16;
    localparam int MAX_VERTICES_DEF = 64;

    // microprogram steps
    typedef enum logic [3:0] {
        ST_CLR,
        ST_PREP,
        ST_LOAD,
        ST_DRAIN,
        ST_ERRW,
        ST_ERR,
        ST_SCANR,
        ST_SCANC,
        ST_SCANI,
        ST_FOUND,
        ST_PARR,
        ST_PARG,
        ST_DECW,
        ST_DEC,
        ST_NEXT
    } step_t;

    // occurrence count read source
    typedef enum logic [1:0] {
        CR_NONE,
        CR_PTR,
        CR_LABEL
    } cnt_rd_t;

    // occurrence count write kind
    typedef enum logic [1:0] {
        CW_NONE,
        CW_ZERO,
        CW_DEC
    } cnt_wr_t;

    // counter operation
    typedef enum logic [1:0] {
        PO_HOLD,
        PO_CLR,
        PO_INC
    } ctr_op_t;

    // working leaf register source
    typedef enum logic [1:0] {
        LF_HOLD,
        LF_PTR,
        LF_PAR
    } leaf_op_t;

    // result beat kind
    typedef enum logic [1:0] {
        EM_NONE,
        EM_EDGE,
        EM_ERR
    } emit_t;

    // branch conditions
    typedef enum logic [2:0] {
        CD_ALWAYS,
        CD_PTR_END,
        CD_LAST_IN,
        CD_BAD,
        CD_OUT_FREE,
        CD_CNT_ZERO,
        CD_POS_LAST,
        CD_TAKE
    } cond_t;

    // one control word of the microprogram
    typedef struct packed {
        logic     ready;
        cnt_rd_t  cr;
        cnt_wr_t  cw;
        ctr_op_t  ptr_op;
        ctr_op_t  pos_op;
        logic     seq_clr;
        logic     lbl_rd;
        logic     par_ld;
        leaf_op_t leaf_op;
        emit_t    emit;
        cond_t    cond;
        step_t    tgt_t;
        step_t    tgt_f;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic ptr_end;
        logic last_in;
        logic bad;
        logic out_free;
        logic cnt_zero;
        logic pos_last;
        logic take;
    } stat_t;

    localparam ctrl_t CTRL_NOP = '{
        ready:   1'b0,
        cr:      CR_NONE,
        cw:      CW_NONE,
        ptr_op:  PO_HOLD,
        pos_op:  PO_HOLD,
        seq_clr: 1'b0,
        lbl_rd:  1'b0,
        par_ld:  1'b0,
        leaf_op: LF_HOLD,
        emit:    EM_NONE,
        cond:    CD_ALWAYS,
        tgt_t:   ST_CLR,
        tgt_f:   ST_CLR
    };

endpackage

`default_nettype wire

### rtl/prufer_sequence_decoder.sv
// Pruefer sequence decoder: streaming label input, tree edge output
//
// Input stream: one vertex label per beat in s_axis_tdata, s_axis_tlast on
// the final label. Labels load at one beat per cycle into the label store.
// After the last beat the block drops s_axis_tready and decodes: each
// position gives one edge beat (leaf, parent) on the master side, with
// m_axis_tlast on the final edge. A label above the label count or too
// many labels gives a single error beat (zeros, tlast and tuser set).
// Decode is run by the microcoded sequencer sharing one port of the
// occurrence count memory. Each edge reads and loads its parent label, reads
// the parent's count, waits for a free result register, then emits the edge
// and decrements that count; a leaf from the smallest-leaf scan is found by
// reading and testing the count of each vertex the scan examines. A good
// decode ends with a setup step before the block loads again.
// After reset, and after an error beat, a clearing pass zeroes all
// MAX_VERTICES occurrence counts, then a setup step follows before
// s_axis_tready rises.
// When the receiver stalls, the result beat holds in its output register
// and the sequencer waits before writing the next one.
`default_nettype none

module prufer_sequence_decoder
    import pfd_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,  // [5:0] vertex_label, [7:6] zero
    input  wire                    s_axis_tlast,  // last_element
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [5:0] leaf_vertex, [11:6] parent_vertex,
                                                  // [15:12] zero
    output logic                   m_axis_tlast,  // last_edge
    output logic                   m_axis_tuser   // bad_sequence
);

    ctrl_t              ctrl;
    stat_t              stat;
    logic [LABEL_W-1:0] leaf;
    logic [LABEL_W-1:0] parent;

    // microprogram control
    pfd_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // storage and working registers
    pfd_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_label   (s_axis_tdata[LABEL_W-1:0]),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_leaf   (leaf),
        .out_parent (parent),
        .out_last   (m_axis_tlast),
        .out_bad    (m_axis_tuser)
    );

    // pack result beat
    assign m_axis_tdata = {{(OUT_TDATA_W - 2 * LABEL_W){1'b0}}, parent, leaf};

endmodule

`default_nettype wire

### rtl/pfd_sequencer.sv
// microcode rom, step counter and branch logic of the decoder
`default_nettype none

module pfd_sequencer
    import pfd_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  cond_true;

    // control store: one word per step
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        c = CTRL_NOP;
        unique case (s)
            ST_CLR:
            begin
                c.cw     = CW_ZERO;
                c.ptr_op = PO_INC;
                c.cond   = CD_PTR_END;
                c.tgt_t  = ST_PREP;
                c.tgt_f  = ST_CLR;
            end
            ST_PREP:
            begin
                c.ptr_op  = PO_CLR;
                c.pos_op  = PO_CLR;
                c.seq_clr = 1'b1;
                c.tgt_t   = ST_LOAD;
                c.tgt_f   = ST_LOAD;
            end
            ST_LOAD:
            begin
                c.ready = 1'b1;
                c.cond  = CD_LAST_IN;
                c.tgt_t = ST_DRAIN;
                c.tgt_f = ST_LOAD;
            end
            ST_DRAIN:
            begin
                c.cond  = CD_BAD;
                c.tgt_t = ST_ERRW;
                c.tgt_f = ST_SCANR;
            end
            ST_ERRW:
            begin
                c.cond  = CD_OUT_FREE;
                c.tgt_t = ST_ERR;
                c.tgt_f = ST_ERRW;
            end
            ST_ERR:
            begin
                c.emit   = EM_ERR;
                c.ptr_op = PO_CLR;
                c.tgt_t  = ST_CLR;
                c.tgt_f  = ST_CLR;
            end
            ST_SCANR:
            begin
                c.cr    = CR_PTR;
                c.tgt_t = ST_SCANC;
                c.tgt_f = ST_SCANC;
            end
            ST_SCANC:
            begin
                c.cond  = CD_CNT_ZERO;
                c.tgt_t = ST_FOUND;
                c.tgt_f = ST_SCANI;
            end
            ST_SCANI:
            begin
                c.ptr_op = PO_INC;
                c.tgt_t  = ST_SCANR;
                c.tgt_f  = ST_SCANR;
            end
            ST_FOUND:
            begin
                c.leaf_op = LF_PTR;
                c.tgt_t   = ST_PARR;
                c.tgt_f   = ST_PARR;
            end
            ST_PARR:
            begin
                c.lbl_rd = 1'b1;
                c.tgt_t  = ST_PARG;
                c.tgt_f  = ST_PARG;
            end
            ST_PARG:
            begin
                c.par_ld = 1'b1;
                c.cr     = CR_LABEL;
                c.tgt_t  = ST_DECW;
                c.tgt_f  = ST_DECW;
            end
            ST_DECW:
            begin
                c.cond  = CD_OUT_FREE;
                c.tgt_t = ST_DEC;
                c.tgt_f = ST_DECW;
            end
            ST_DEC:
            begin
                c.cw     = CW_DEC;
                c.emit   = EM_EDGE;
                c.pos_op = PO_INC;
                c.cond   = CD_POS_LAST;
                c.tgt_t  = ST_PREP;
                c.tgt_f  = ST_NEXT;
            end
            ST_NEXT:
            begin
                c.leaf_op = LF_PAR;
                c.cond    = CD_TAKE;
                c.tgt_t   = ST_PARR;
                c.tgt_f   = ST_SCANI;
            end
            default:
            begin
                c = CTRL_NOP;
            end
        endcase
        return c;
    endfunction

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // control word and branch select
    always_comb
    begin
        ctrl = ucode(step_reg);
        unique case (ctrl.cond)
            CD_ALWAYS:   cond_true = 1'b1;
            CD_PTR_END:  cond_true = stat.ptr_end;
            CD_LAST_IN:  cond_true = stat.last_in;
            CD_BAD:      cond_true = stat.bad;
            CD_OUT_FREE: cond_true = stat.out_free;
            CD_CNT_ZERO: cond_true = stat.cnt_zero;
            CD_POS_LAST: cond_true = stat.pos_last;
            CD_TAKE:     cond_true = stat.take;
            default:     cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctrl.tgt_t : ctrl.tgt_f;
    end

endmodule

`default_nettype wire

### rtl/pfd_datapath.sv
// label store, occurrence counts, pointers and result register of the decoder
`default_nettype none

module pfd_datapath
    import pfd_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  ctrl_t              ctrl,
    output stat_t              stat,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [LABEL_W-1:0] in_label,
    input  wire                in_last,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [LABEL_W-1:0] out_leaf,
    output logic [LABEL_W-1:0] out_parent,
    output logic               out_last,
    output logic               out_bad
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int SD = MAX_VERTICES - 1;
    localparam int SW = (SD > 1) ? $clog2(SD) : 1;
    localparam int XW = ((AW > LABEL_W) ? AW : LABEL_W) + 1;

    // memories
    logic [AW-1:0]      cnt_mem [MAX_VERTICES];
    logic [LABEL_W-1:0] lbl_mem [SD];

    // sequence bookkeeping
    logic [AW-1:0]      elem_cnt_reg;
    logic               ovf_reg;
    logic [LABEL_W-1:0] max_reg;

    // load increment pipeline and forwarding
    logic               p_valid_reg;
    logic [AW-1:0]      p_addr_reg;
    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [AW-1:0]      fwd_data_reg;

    // decode working registers
    logic [AW-1:0]      cnt_rdata_reg;
    logic [LABEL_W-1:0] lbl_rdata_reg;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      leaf_reg;
    logic [LABEL_W-1:0] par_reg;

    // result register
    logic               out_valid_reg;
    logic [LABEL_W-1:0] out_leaf_reg;
    logic [LABEL_W-1:0] out_par_reg;
    logic               out_last_reg;
    logic               out_bad_reg;

    logic               accept;
    logic               full;
    logic               store;
    logic               count_en;
    logic [AW-1:0]      inc_base;
    logic [AW-1:0]      inc_val;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      wr_data;
    logic               pos_last;

    // load side handshake
    always_comb
    begin
        in_ready = ctrl.ready;
        accept   = in_valid && ctrl.ready;
        full     = (elem_cnt_reg == AW'(SD));
        store    = accept && !full;
        count_en = store && (XW'(in_label) < XW'(MAX_VERTICES));
        inc_base = (fwd_valid_reg && (fwd_addr_reg == p_addr_reg)) ? fwd_data_reg
                                                                    : cnt_rdata_reg;
        inc_val  = inc_base + AW'(1);
        pos_last = (pos_reg == (elem_cnt_reg - AW'(1)));
    end

    // count memory port select
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        if (count_en)
        begin
            rd_en   = 1'b1;
            rd_addr = AW'(in_label);
        end
        else
        begin
            unique case (ctrl.cr)
                CR_PTR:
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg;
                end
                CR_LABEL:
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(lbl_rdata_reg);
                end
                default:
                begin
                    rd_en   = 1'b0;
                end
            endcase
        end

        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = '0;
        if (p_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = p_addr_reg;
            wr_data = inc_val;
        end
        else
        begin
            unique case (ctrl.cw)
                CW_ZERO:
                begin
                    wr_en   = 1'b1;
                    wr_addr = ptr_reg;
                    wr_data = '0;
                end
                CW_DEC:
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(par_reg);
                    wr_data = cnt_rdata_reg - AW'(1);
                end
                default:
                begin
                    wr_en   = 1'b0;
                end
            endcase
        end
    end

    // occurrence count memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            cnt_rdata_reg <= cnt_mem[rd_addr];
        end
    end

    // label store memory
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            lbl_mem[elem_cnt_reg[SW-1:0]] <= in_label;
        end
        if (ctrl.lbl_rd)
        begin
            lbl_rdata_reg <= lbl_mem[pos_reg[SW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            max_reg       <= '0;
            p_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.seq_clr)
            begin
                elem_cnt_reg <= '0;
                ovf_reg      <= 1'b0;
                max_reg      <= '0;
            end
            else if (accept)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    elem_cnt_reg <= elem_cnt_reg + AW'(1);
                end
                if (in_label > max_reg)
                begin
                    max_reg <= in_label;
                end
            end

            p_valid_reg   <= count_en;
            fwd_valid_reg <= p_valid_reg;

            unique case (ctrl.ptr_op)
                PO_CLR:  ptr_reg <= '0;
                PO_INC:  ptr_reg <= ptr_reg + AW'(1);
                default: ptr_reg <= ptr_reg;
            endcase

            unique case (ctrl.pos_op)
                PO_CLR:  pos_reg <= '0;
                PO_INC:  pos_reg <= pos_reg + AW'(1);
                default: pos_reg <= pos_reg;
            endcase

            if (ctrl.emit != EM_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (count_en)
        begin
            p_addr_reg <= AW'(in_label);
        end
        fwd_addr_reg <= p_addr_reg;
        fwd_data_reg <= inc_val;

        if (ctrl.par_ld)
        begin
            par_reg <= lbl_rdata_reg;
        end

        unique case (ctrl.leaf_op)
            LF_PTR:  leaf_reg <= ptr_reg;
            LF_PAR:  leaf_reg <= AW'(par_reg);
            default: leaf_reg <= leaf_reg;
        endcase

        unique case (ctrl.emit)
            EM_EDGE:
            begin
                out_leaf_reg <= LABEL_W'(leaf_reg);
                out_par_reg  <= par_reg;
                out_last_reg <= pos_last;
                out_bad_reg  <= 1'b0;
            end
            EM_ERR:
            begin
                out_leaf_reg <= '0;
                out_par_reg  <= '0;
                out_last_reg <= 1'b1;
                out_bad_reg  <= 1'b1;
            end
            default:
            begin
                out_leaf_reg <= out_leaf_reg;
            end
        endcase
    end

    // status to the sequencer
    always_comb
    begin
        stat.ptr_end  = (ptr_reg == AW'(MAX_VERTICES - 1));
        stat.last_in  = accept && in_last;
        stat.bad      = ovf_reg || (XW'(max_reg) > XW'(elem_cnt_reg));
        stat.out_free = !out_valid_reg || out_ready;
        stat.cnt_zero = (cnt_rdata_reg == '0);
        stat.pos_last = pos_last;
        stat.take     = (cnt_rdata_reg == AW'(1)) && (XW'(par_reg) < XW'(ptr_reg));
    end

    // result outputs
    assign out_valid  = out_valid_reg;
    assign out_leaf   = out_leaf_reg;
    assign out_parent = out_par_reg;
    assign out_last   = out_last_reg;
    assign out_bad    = out_bad_reg;

`ifndef SYNTHESIS
    // the load increment never shares the write port with a decode write
    a_wr_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (ctrl.cw == CW_NONE))
        else $error("count write port collision");

    // a result is only written into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit != EM_NONE) |-> !out_valid_reg)
        else $error("result overwritten before taken");

    // the leaf scan stays within the vertex range of the sequence
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cr == CR_PTR) |-> (ptr_reg <= elem_cnt_reg))
        else $error("leaf scan ran past the last vertex");

    // a new result beat only appears after an emit step
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.emit != EM_NONE))
        else $error("result valid without emit");
`endif

endmodule

`default_nettype wire

### tb/tb_prufer_sequence_decoder.sv
// testbench for the pruefer sequence decoder: label stream in, checked edge stream out
`timescale 1ns / 100ps

module tb_prufer_sequence_decoder;
    import pfd_pkg::*;

    localparam int MAX_LABELS  = MAX_VERTICES_DEF - 1;
    localparam int IDLE_LIMIT  = 5000;
    localparam int ITEM_BUDGET = 310;
    localparam int TAIL_CYCLES = 600;

    // one decoded result beat
    typedef struct packed {
        logic [LABEL_W-1:0] leaf;
        logic [LABEL_W-1:0] parent;
        logic               last;
        logic               bad;
    } edge_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [5:0] vertex_label, [7:6] zero
    logic                   s_axis_tlast;   // last_element
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [5:0] leaf_vertex, [11:6] parent_vertex, [15:12] zero
    logic                   m_axis_tlast;   // last_edge
    logic                   m_axis_tuser;   // bad_sequence

    // predicted decoder state
    logic [LABEL_W-1:0] lbl_mem [MAX_LABELS];
    int                 occ_cnt [MAX_VERTICES_DEF];
    int                 lbl_cnt;
    bit                 ovf_seen;
    edge_beat_t         edge_q [$];

    int errors      = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int rx_hold     = 0;
    int idle_cycles = 0;

    prufer_sequence_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // clear the per-sequence part of the predicted state
    function automatic void clear_sequence_state();
        occ_cnt  = '{default: 0};
        lbl_cnt  = 0;
        ovf_seen = 1'b0;
    endfunction

    // take one accepted label, and on the last one queue the decoded edges
    function automatic void absorb_label(logic [LABEL_W-1:0] lbl, logic lst);
        int         n;
        int         i;
        int         v;
        int         leaf;
        bit         bad;
        bit         taken [MAX_VERTICES_DEF];
        edge_beat_t e;
        if (lbl_cnt < MAX_LABELS)
        begin
            lbl_mem[lbl_cnt] = lbl;
            occ_cnt[lbl]++;
            lbl_cnt++;
        end
        else
            ovf_seen = 1'b1;
        if (!lst)
            return;
        n   = lbl_cnt;
        bad = ovf_seen;
        for (i = 0; i < n; i++)
            if (lbl_mem[i] > n)
                bad = 1'b1;
        if (bad)
        begin
            e.leaf   = '0;
            e.parent = '0;
            e.last   = 1'b1;
            e.bad    = 1'b1;
            edge_q.push_back(e);
        end
        else
        begin
            taken = '{default: 1'b0};
            for (i = 0; i < n; i++)
            begin
                // smallest vertex not used and absent from the rest of the sequence
                leaf = 0;
                for (v = 0; v <= n && v < MAX_VERTICES_DEF; v++)
                    if (occ_cnt[v] == 0 && !taken[v])
                    begin
                        leaf = v;
                        break;
                    end
                taken[leaf] = 1'b1;
                if (occ_cnt[lbl_mem[i]] > 0)
                    occ_cnt[lbl_mem[i]]--;
                e.leaf   = LABEL_W'(leaf);
                e.parent = lbl_mem[i];
                e.last   = (i + 1 == n);
                e.bad    = 1'b0;
                edge_q.push_back(e);
            end
        end
        clear_sequence_state();
    endfunction

    // offer one label beat, wait for it to be taken, then maybe open a gap
    task automatic send_label(input logic [LABEL_W-1:0] lbl, input logic lst);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, lbl};
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_label(lbl, lst);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_sequence(input logic [LABEL_W-1:0] labels [$]);
        int i;
        for (i = 0; i < labels.size(); i++)
            send_label(labels[i], i == labels.size() - 1);
    endtask

    // stop offering and wait until every predicted beat has come out
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (edge_q.size() != 0)
            @(negedge clk);
    endtask

    // short sequences: field extremes, bad labels, stars and paths
    task automatic test_directed();
        logic [LABEL_W-1:0] seq [$];
        seq = '{6'd0};
        send_sequence(seq);
        seq = '{6'd1};
        send_sequence(seq);
        seq = '{6'd2};
        send_sequence(seq);
        seq = '{6'd63};
        send_sequence(seq);
        seq = '{6'd2, 6'd2};
        send_sequence(seq);
        seq = '{6'd0, 6'd0, 6'd0};
        send_sequence(seq);
        seq = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4};
        send_sequence(seq);
        seq = '{6'd5, 6'd5, 6'd5, 6'd5, 6'd5};
        send_sequence(seq);
        seq = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd7};
        send_sequence(seq);
        wait_drain();
    endtask

    // longest legal sequence, then one label too many
    task automatic test_long_sequences();
        int i;
        for (i = 0; i < MAX_LABELS; i++)
            send_label((i == 0) ? 6'd63 : LABEL_W'($urandom_range(0, MAX_LABELS)),
                       i == MAX_LABELS - 1);
        wait_drain();
        for (i = 0; i <= MAX_LABELS; i++)
            send_label(LABEL_W'($urandom_range(0, 10)), i == MAX_LABELS);
        wait_drain();
    endtask

    // receiver holds off while several sequences are offered back to back
    task automatic test_output_backpressure();
        int s;
        int i;
        int n;
        rx_hold = 300;
        for (s = 0; s < 4; s++)
        begin
            n = $urandom_range(4, 8);
            for (i = 0; i < n; i++)
                send_label(LABEL_W'($urandom_range(0, n)), i == n - 1);
        end
        wait_drain();
    endtask

    // random sequences, mostly well formed, some with a bad label or pure noise
    task automatic send_random_sequence();
        int                 r;
        int                 n;
        int                 kind;
        int                 bad_pos;
        int                 i;
        logic [LABEL_W-1:0] lbl;
        r = $urandom_range(0, 19);
        n = (r == 0) ? $urandom_range(40, MAX_LABELS) :
            (r < 5)  ? $urandom_range(13, 30) : $urandom_range(1, 12);
        kind    = $urandom_range(0, 19);
        bad_pos = $urandom_range(0, n - 1);
        for (i = 0; i < n; i++)
        begin
            lbl = LABEL_W'($urandom_range(0, n));
            if (kind >= 16 && kind < 19 && n < MAX_LABELS && i == bad_pos)
                lbl = LABEL_W'($urandom_range(n + 1, 63));
            else if (kind == 19)
                lbl = LABEL_W'($urandom_range(0, 63));
            send_label(lbl, i == n - 1);
        end
    endtask

    task automatic test_random();
        while (items_sent < ITEM_BUDGET)
        begin
            send_random_sequence();
            if ($urandom_range(0, 4) == 0)
                wait_drain();
        end
        wait_drain();
    endtask

    // receiver ready pattern, with a forced hold-off on request
    initial
    begin
        int stretch;
        int mode;
        m_axis_tready = 1'b0;
        stretch       = 0;
        mode          = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(10, 120);
                end
                stretch--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic report_mismatch(input string fld, input logic [LABEL_W-1:0] want_v,
                                   input logic [LABEL_W-1:0] got_v);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fld, want_v, got_v);
        errors++;
    endtask

    // result check and stall watchdog
    always @(posedge clk)
    begin
        edge_beat_t got;
        edge_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.leaf   = m_axis_tdata[LABEL_W-1:0];
            got.parent = m_axis_tdata[2*LABEL_W-1:LABEL_W];
            got.last   = m_axis_tlast;
            got.bad    = m_axis_tuser;
            if (edge_q.size() == 0)
            begin
                $display("%0t ns: unexpected beat, expected none, actual leaf %0d parent %0d",
                         $time, got.leaf, got.parent);
                errors++;
            end
            else
            begin
                want = edge_q.pop_front();
                if (got.leaf !== want.leaf)
                    report_mismatch("leaf_vertex", want.leaf, got.leaf);
                if (got.parent !== want.parent)
                    report_mismatch("parent_vertex", want.parent, got.parent);
                if (got.last !== want.last)
                    report_mismatch("last_edge", LABEL_W'(want.last), LABEL_W'(got.last));
                if (got.bad !== want.bad)
                    report_mismatch("bad_sequence", LABEL_W'(want.bad), LABEL_W'(got.bad));
            end
        end
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        rst_n         = 1'b0;
        lbl_mem       = '{default: '0};
        clear_sequence_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_long_sequences();
        test_output_backpressure();
        test_random();

        // let any trailing activity settle
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
